// File: hw/rtl/c8_pkg.sv
// Shared types and constants of the CHIP-8 interpreter core.
package c8_pkg;

  localparam int ADDR_W   = 12;
  localparam int MEM_SIZE = 4096;
  localparam int ROWS     = 32;
  localparam int ROW_W    = 5;
  localparam int PIX_W    = 64;

  // Item kinds on the input channel
  localparam logic [1:0] OPER_EXEC  = 2'd0;
  localparam logic [1:0] OPER_WRITE = 2'd1;
  localparam logic [1:0] OPER_READ  = 2'd2;
  localparam logic [1:0] OPER_ROW   = 2'd3;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  // Opcode groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV  = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;

  localparam logic [7:0] FX_GET_DT = 8'h07;
  localparam logic [7:0] FX_WAIT   = 8'h0A;
  localparam logic [7:0] FX_SET_DT = 8'h15;
  localparam logic [7:0] FX_SET_ST = 8'h18;
  localparam logic [7:0] FX_ADD_I  = 8'h1E;
  localparam logic [7:0] FX_FONT   = 8'h29;
  localparam logic [7:0] FX_BCD    = 8'h33;
  localparam logic [7:0] FX_STORE  = 8'h55;
  localparam logic [7:0] FX_LOAD   = 8'h65;

  // 8xyN operation codes
  localparam logic [3:0] ALU_LD   = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [15:0] FONT_BASE = 16'h0050;
  localparam logic [11:0] PC_START  = 12'h200;
  localparam logic [4:0]  NO_WAIT   = 5'd16;
  localparam logic [3:0]  FLAG_REG  = 4'hF;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       wr_x;
    logic       wr_flag;
  } alu_out_t;

endpackage

// File: hw/rtl/c8_alu.sv
// Register-to-register arithmetic of the 8xyN opcodes.
module c8_alu (
  input  logic [7:0]       a,
  input  logic [7:0]       b,
  input  logic [3:0]       n,
  output c8_pkg::alu_out_t result
);
  import c8_pkg::*;

  logic [8:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};

  // Pick result and flag per operation code
  always_comb begin
    result = '0;
    unique case (n)
      ALU_LD: begin
        result.res = b; result.wr_x = 1'b1;
      end
      ALU_OR: begin
        result.res = a | b; result.wr_x = 1'b1;
      end
      ALU_AND: begin
        result.res = a & b; result.wr_x = 1'b1;
      end
      ALU_XOR: begin
        result.res = a ^ b; result.wr_x = 1'b1;
      end
      ALU_ADD: begin
        result = '{res: sum[7:0], flag: sum[8], wr_x: 1'b1, wr_flag: 1'b1};
      end
      ALU_SUB: begin
        result = '{res: a - b, flag: (a >= b), wr_x: 1'b1, wr_flag: 1'b1};
      end
      ALU_SHR: begin
        result = '{res: {1'b0, a[7:1]}, flag: a[0], wr_x: 1'b1, wr_flag: 1'b1};
      end
      ALU_SUBN: begin
        result = '{res: b - a, flag: (b >= a), wr_x: 1'b1, wr_flag: 1'b1};
      end
      ALU_SHL: begin
        result = '{res: {a[6:0], 1'b0}, flag: a[7], wr_x: 1'b1, wr_flag: 1'b1};
      end
      default: result = '0;
    endcase
  end

endmodule

// File: hw/rtl/chip8_cpu_core.sv
// CHIP-8 interpreter core: sequencer around program memory, screen and registers.
//
// Input channel s_*: one item per operation. s_tuser selects execute one
// instruction, write a memory byte, read a memory byte or read a screen row.
// Output channel m_*: exactly one result item per input item, carrying the
// read data, program counter, both timer registers and the key-wait register.
// Every access goes through synchronous memories with a registered read port
// (4 KiB program memory, 32 x 64 screen, 16 byte registers), so an item walks
// a sequencer one memory step per cycle, waiting only while its result is held:
//   memory write one access step, memory or row read an access and a capture,
//   plain instruction two fetch reads, three register reads and the execution,
//   flag-setting ALU op adds a flag write, draw a read and write per sprite row,
//   BCD three digit writes, register store or load a read and write per register.
// A new item is taken only while the sequencer is idle; the result sits in an
// output register, so the next item may start while that result is unclaimed,
// and its own result waits until the receiver takes the previous one.
// Reset clears registers, stack pointer, timers and screen at once and sets
// the program counter to 0x200; program memory and return stack hold
// whatever was written to them.
module chip8_cpu_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // keys_down[15:0], random_byte[23:16], address[35:24], write_data[43:36]
  input  logic [47:0]  s_tdata,
  // operation[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // read_data[63:0], program_counter[75:64], delay_value[83:76],
  // sound_value[91:84], key_wait_register[96:92]
  output logic [103:0] m_tdata
);
  import c8_pkg::*;

  localparam int SW = $clog2(STACK_DEPTH);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_OPS  = 5'd1;
  localparam logic [4:0] S_RDW  = 5'd2;
  localparam logic [4:0] S_F0   = 5'd3;
  localparam logic [4:0] S_F1   = 5'd4;
  localparam logic [4:0] S_F2   = 5'd5;
  localparam logic [4:0] S_RX   = 5'd6;
  localparam logic [4:0] S_RY   = 5'd7;
  localparam logic [4:0] S_R0   = 5'd8;
  localparam logic [4:0] S_EXEC = 5'd9;
  localparam logic [4:0] S_WF   = 5'd10;
  localparam logic [4:0] S_DR   = 5'd11;
  localparam logic [4:0] S_DW   = 5'd12;
  localparam logic [4:0] S_BCD  = 5'd13;
  localparam logic [4:0] S_SR   = 5'd14;
  localparam logic [4:0] S_SW   = 5'd15;
  localparam logic [4:0] S_LR   = 5'd16;
  localparam logic [4:0] S_LW   = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  logic [4:0]  state;
  logic [1:0]  oper;
  logic [15:0] keys;
  logic [7:0]  rnd;
  logic [11:0] addr;
  logic [7:0]  wdata;
  logic [63:0] rdata;

  logic [11:0] pc;
  logic [15:0] ireg;
  logic [4:0]  sp;
  logic [7:0]  delay;
  logic [7:0]  sound;
  logic [4:0]  wait_reg;
  logic [7:0]  op_hi;
  logic [7:0]  op_lo;
  logic [7:0]  vx;
  logic [7:0]  vy;
  logic [7:0]  v0;
  logic [3:0]  cnt;
  logic        hit;
  logic        flag;

  // Program memory
  logic [7:0]  mem [MEM_SIZE];
  logic [7:0]  mem_q;
  logic [11:0] mem_ra;
  logic [11:0] mem_wa;
  logic [7:0]  mem_wd;
  logic        mem_we;

  // Byte registers V0-VF
  logic [7:0]  vreg [16];
  logic [15:0] v_vld;
  logic [7:0]  v_q;
  logic        v_vld_q;
  logic [7:0]  v_rd;
  logic [3:0]  v_ra;
  logic [3:0]  v_wa;
  logic [7:0]  v_wd;
  logic        v_we;

  // Screen
  logic [63:0]    fb [ROWS];
  logic [ROWS-1:0] fb_vld;
  logic [63:0]    fb_q;
  logic           fb_vld_q;
  logic [63:0]    fb_rd;
  logic [ROW_W-1:0] fb_ra;
  logic           fb_we;

  // Return stack
  logic [11:0] stack [STACK_DEPTH];
  logic        push;
  logic [4:0]  sp_m1;

  logic [3:0]  grp;
  logic [3:0]  rx;
  logic [3:0]  ry;
  logic [3:0]  nib;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [15:0] opcode;
  logic [11:0] pc_inc;
  logic [11:0] pc_skip;
  logic [11:0] pc_next;
  logic [4:0]  exec_state_next;
  logic [11:0] i_addr;
  logic [ROW_W-1:0] draw_row;
  logic [127:0] spr_dbl;
  logic [63:0]  spr;
  logic [63:0]  row_new;
  logic         key_hit;
  logic [1:0]   hund;
  logic [7:0]   rem;
  logic [14:0]  tens_prod;
  logic [3:0]   tens;
  logic [7:0]   ones;
  logic [7:0]   digit;
  alu_out_t     alu;

  // Decode the fetched opcode
  assign opcode  = {op_hi, op_lo};
  assign grp     = op_hi[7:4];
  assign rx      = op_hi[3:0];
  assign ry      = op_lo[7:4];
  assign nib     = op_lo[3:0];
  assign kk      = op_lo;
  assign nnn     = {op_hi[3:0], op_lo};
  assign pc_inc  = pc + 12'd2;
  assign pc_skip = pc + 12'd4;
  assign i_addr  = ireg[11:0] + {8'd0, cnt};
  assign draw_row = vy[ROW_W-1:0] + {1'b0, cnt};
  assign key_hit = keys[vx[3:0]];
  assign sp_m1   = sp - 5'd1;
  assign push    = (state == S_EXEC) && (grp == GRP_CALL) && (sp < 5'(STACK_DEPTH));

  assign v_rd  = v_vld_q ? v_q : 8'd0;
  assign fb_rd = fb_vld_q ? fb_q : 64'd0;

  // Place the sprite byte at column vx, wrapping around the row
  assign spr_dbl = {mem_q, 56'd0, mem_q, 56'd0} >> vx[5:0];
  assign spr     = spr_dbl[63:0];
  assign row_new = fb_rd ^ spr;

  // Decimal digits of vx
  assign hund      = (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
  assign rem       = vx - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
  assign tens_prod = 15'(rem[6:0] * 8'd205);
  assign tens      = tens_prod[14:11];
  assign ones      = rem - 8'(tens * 4'd10);

  always_comb begin
    case (cnt)
      4'd0:    digit = {6'd0, hund};
      4'd1:    digit = {4'd0, tens};
      default: digit = ones;
    endcase
  end

  c8_alu u_alu (
    .a      (vx),
    .b      (vy),
    .n      (nib),
    .result (alu)
  );

  assign s_tready = (state == S_IDLE);

  // Pick the program counter and follow-up step of the executed instruction
  always_comb begin
    pc_next         = pc_inc;
    exec_state_next = S_DONE;
    case (grp)
      GRP_SYS: begin
        if ((opcode == OP_RET) && (sp != 5'd0)) begin
          pc_next = stack[sp_m1[SW-1:0]];
        end
      end
      GRP_JP:   pc_next = nnn;
      GRP_CALL: pc_next = nnn;
      GRP_SE:   if (vx == kk) pc_next = pc_skip;
      GRP_SNE:  if (vx != kk) pc_next = pc_skip;
      GRP_SER:  if (vx == vy) pc_next = pc_skip;
      GRP_SNER: if (vx != vy) pc_next = pc_skip;
      GRP_ALU:  if (alu.wr_flag) exec_state_next = S_WF;
      GRP_JPV:  pc_next = nnn + {4'd0, v0};
      GRP_DRW:  exec_state_next = (nib == 4'd0) ? S_WF : S_DR;
      GRP_KEY: begin
        if (((kk == KK_SKP) && key_hit) || ((kk == KK_SKNP) && !key_hit)) begin
          pc_next = pc_skip;
        end
      end
      GRP_MISC: begin
        case (kk)
          FX_BCD:   exec_state_next = S_BCD;
          FX_STORE: exec_state_next = S_SR;
          FX_LOAD:  exec_state_next = S_LR;
          default:  exec_state_next = S_DONE;
        endcase
      end
      default: exec_state_next = S_DONE;
    endcase
  end

  // Drive the memory ports from the sequencer state
  always_comb begin
    mem_ra = pc;
    mem_we = 1'b0;
    mem_wa = i_addr;
    mem_wd = digit;
    v_ra   = 4'd0;
    v_we   = 1'b0;
    v_wa   = rx;
    v_wd   = kk;
    fb_ra  = draw_row;
    fb_we  = 1'b0;
    unique case (state)
      S_OPS: begin
        mem_ra = addr;
        mem_wa = addr;
        mem_wd = wdata;
        mem_we = (oper == OPER_WRITE);
        fb_ra  = addr[ROW_W-1:0];
      end
      S_F1:  mem_ra = pc + 12'd1;
      S_F2:  v_ra = rx;
      S_RX:  v_ra = ry;
      S_EXEC: begin
        case (grp)
          GRP_LD:  v_we = 1'b1;
          GRP_ADD: begin
            v_we = 1'b1; v_wd = vx + kk;
          end
          GRP_RND: begin
            v_we = 1'b1; v_wd = rnd & kk;
          end
          GRP_ALU: begin
            v_we = alu.wr_x; v_wd = alu.res;
          end
          GRP_MISC: begin
            v_we = (kk == FX_GET_DT); v_wd = delay;
          end
          default: v_we = 1'b0;
        endcase
      end
      S_WF: begin
        v_we = 1'b1; v_wa = FLAG_REG; v_wd = {7'd0, flag};
      end
      S_DR:  mem_ra = i_addr;
      S_DW:  fb_we = 1'b1;
      S_BCD: mem_we = 1'b1;
      S_SR:  v_ra = cnt;
      S_SW: begin
        mem_we = 1'b1; mem_wd = v_rd;
      end
      S_LR:  mem_ra = i_addr;
      S_LW: begin
        v_we = 1'b1; v_wa = cnt; v_wd = mem_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Program memory port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  // Register file and screen arrays
  always_ff @(posedge clk) begin
    if (v_we) begin
      vreg[v_wa] <= v_wd;
    end
    v_q <= vreg[v_ra];
    if (fb_we) begin
      fb[draw_row] <= row_new;
    end
    fb_q <= fb[fb_ra];
  end

  // Return stack
  always_ff @(posedge clk) begin
    if (push) begin
      stack[sp[SW-1:0]] <= pc_inc;
    end
  end

  // Valid bits standing in for the cleared reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      v_vld    <= '0;
      v_vld_q  <= 1'b0;
      fb_vld   <= '0;
      fb_vld_q <= 1'b0;
    end else begin
      if (v_we) begin
        v_vld[v_wa] <= 1'b1;
      end
      v_vld_q  <= v_vld[v_ra];
      fb_vld_q <= fb_vld[fb_ra];
      if (fb_we) begin
        fb_vld[draw_row] <= 1'b1;
      end
      if ((state == S_EXEC) && (grp == GRP_SYS) && (opcode == OP_CLS)) begin
        fb_vld <= '0;
      end
    end
  end

  // Input latches and working registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      oper  <= s_tuser;
      keys  <= s_tdata[15:0];
      rnd   <= s_tdata[23:16];
      addr  <= s_tdata[35:24];
      wdata <= s_tdata[43:36];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= PC_START;
      ireg     <= 16'd0;
      sp       <= 5'd0;
      delay    <= 8'd0;
      sound    <= 8'd0;
      wait_reg <= NO_WAIT;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            rdata <= 64'd0;
            state <= (s_tuser == OPER_EXEC) ? S_F0 : S_OPS;
          end
        end
        S_OPS: state <= (oper == OPER_WRITE) ? S_DONE : S_RDW;
        S_RDW: begin
          rdata <= (oper == OPER_READ) ? {56'd0, mem_q} : fb_rd;
          state <= S_DONE;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          op_hi <= mem_q;
          state <= S_F2;
        end
        S_F2: begin
          op_lo <= mem_q;
          state <= S_RX;
        end
        S_RX: begin
          vx    <= v_rd;
          state <= S_RY;
        end
        S_RY: begin
          vy    <= v_rd;
          state <= S_R0;
        end
        S_R0: begin
          v0    <= v_rd;
          state <= S_EXEC;
        end
        S_EXEC: begin
          pc    <= pc_next;
          cnt   <= 4'd0;
          hit   <= 1'b0;
          state <= exec_state_next;
          case (grp)
            GRP_SYS: begin
              if ((opcode == OP_RET) && (sp != 5'd0)) begin
                sp <= sp_m1;
              end
            end
            GRP_CALL: begin
              if (push) begin
                sp <= sp + 5'd1;
              end
            end
            GRP_ALU: begin
              if (alu.wr_flag) begin
                flag <= alu.flag;
              end
            end
            GRP_LDI: ireg <= {4'd0, nnn};
            GRP_DRW: begin
              if (nib == 4'd0) begin
                flag <= 1'b0;
              end
            end
            GRP_MISC: begin
              case (kk)
                FX_WAIT:   wait_reg <= {1'b0, rx};
                FX_SET_DT: delay <= vx;
                FX_SET_ST: sound <= vx;
                FX_ADD_I:  ireg <= ireg + {8'd0, vx};
                FX_FONT:   ireg <= FONT_BASE + {10'd0, vx[3:0], 2'd0} + {12'd0, vx[3:0]};
                default:   ;
              endcase
            end
            default: ;
          endcase
        end
        S_WF: state <= S_DONE;
        S_DR: state <= S_DW;
        S_DW: begin
          hit <= hit | (|(fb_rd & spr));
          if (cnt == nib - 4'd1) begin
            flag  <= hit | (|(fb_rd & spr));
            state <= S_WF;
          end else begin
            cnt   <= cnt + 4'd1;
            state <= S_DR;
          end
        end
        S_BCD: begin
          if (cnt == 4'd2) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_SR: state <= S_SW;
        S_SW: begin
          if (cnt == rx) begin
            state <= S_DONE;
          end else begin
            cnt   <= cnt + 4'd1;
            state <= S_SR;
          end
        end
        S_LR: state <= S_LW;
        S_LW: begin
          if (cnt == rx) begin
            state <= S_DONE;
          end else begin
            cnt   <= cnt + 4'd1;
            state <= S_LR;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {7'd0, wait_reg, sound, delay, pc, rdata};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Stack pointer stays within the stack
  assert property (@(posedge clk) disable iff (rst) sp <= 5'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // Key-wait register holds a register number or the none code
  assert property (@(posedge clk) disable iff (rst) wait_reg <= NO_WAIT)
    else $error("key-wait register out of range");

  // An accepted item occupies the sequencer on the next cycle
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("sequencer took an item without leaving idle");

  // A result is only offered by leaving the final state
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the final state");

endmodule
